// ===== rtl/isofrm_pkg.sv =====
// Shared types, constants and CRC helpers for the ISO 14443-4 I-block framer.
// Used by isofrm_front, isofrm_queue, isofrm_back and the top level.
// No dependencies.
package isofrm_pkg;

	localparam int MAX_RESULTS = 4;
	localparam int RES_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;
	localparam int MSG_CNT_W   = 12;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;

	localparam logic [MSG_CNT_W-1:0] MAX_MESSAGE_BYTES = 12'd4095;

	localparam logic [8:0]  FRAME_SIZE_MIN   = 9'd16;
	localparam logic [8:0]  FRAME_SIZE_MAX   = 9'd256;
	localparam logic [8:0]  FRAME_SIZE_RESET = 9'd256;
	localparam logic [8:0]  FRAME_OVERHEAD   = 9'd3;

	localparam logic [15:0] CRC_A_INIT = 16'h6363;
	localparam logic [15:0] CRC_B_INIT = 16'hFFFF;

	localparam logic [7:0]  PCB_CHAIN     = 8'h12;
	localparam logic [7:0]  PCB_LAST      = 8'h02;
	localparam logic [7:0]  PCB_BLOCK_NUM = 8'h01;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_VARIANT = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [14:0] message_bits;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] block_length;
		logic       block_first;
		logic       block_last;
		logic       message_done;
		logic       run_last;
	} out_item_t;

	// one result without run_last; the back end derives that from the record
	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] block_length;
		logic       block_first;
		logic       block_last;
		logic       message_done;
	} res_entry_t;

	typedef struct packed {
		res_entry_t [MAX_RESULTS-1:0] ent;
		logic [RES_IDX_W-1:0]         last_idx;
	} rec_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} push_t;

	typedef struct packed {
		logic [7:0]  pcb;
		logic [7:0]  blb;
		logic [7:0]  len;
		logic [15:0] crc;
	} open_t;

	function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
	endfunction

	function automatic logic [15:0] crc_final(logic [15:0] crc, logic variant);
		return variant ? ~crc : crc;
	endfunction

	function automatic open_t open_block(logic [MSG_CNT_W-1:0] blm, logic toggle,
			logic [7:0] payload, logic variant);
		open_t o;
		if (blm > {4'h0, payload}) begin
			o.blb = payload;
			o.pcb = PCB_CHAIN;
		end else begin
			o.blb = blm[7:0];
			o.pcb = PCB_LAST;
		end
		o.pcb = o.pcb | (toggle ? PCB_BLOCK_NUM : 8'h00);
		o.len = o.blb + 8'd1;
		o.crc = crc_feed(variant ? CRC_B_INIT : CRC_A_INIT, o.pcb);
		return o;
	endfunction

	function automatic res_entry_t mk_entry(logic [7:0] b, logic [7:0] len, logic first,
			logic last, logic done);
		res_entry_t e;
		e.out_byte     = b;
		e.block_length = len;
		e.block_first  = first;
		e.block_last   = last;
		e.message_done = done;
		return e;
	endfunction

endpackage

// ===== rtl/isofrm_front.sv =====
// Front end: configuration registers, framing state and per-item result records.
// Each accepted item that produces output is turned into one record of up to four result bytes.
// Depends on isofrm_pkg.
module isofrm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  isofrm_pkg::in_item_t              in_data,
	input  logic                              cfg_we,
	input  logic [isofrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [isofrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                              q_full,
	output isofrm_pkg::push_t                 push
);

	logic [8:0]                       frame_size_q;
	logic                             crc_variant_q;
	logic                             toggle_q;
	logic [isofrm_pkg::MSG_CNT_W-1:0] blm_q;
	logic [7:0]                       blb_q;
	logic [15:0]                      crc_q;
	logic                             active_q;
	logic [7:0]                       len_q;

	logic                             toggle_d;
	logic [isofrm_pkg::MSG_CNT_W-1:0] blm_d;
	logic [7:0]                       blb_d;
	logic [15:0]                      crc_d;
	logic                             active_d;
	logic [7:0]                       len_d;

	logic                             accept;
	logic                             produce;
	logic [7:0]                       payload;
	logic [isofrm_pkg::MSG_CNT_W-1:0] start_bytes;
	logic [isofrm_pkg::MSG_CNT_W-1:0] blm_dec;
	logic [7:0]                       blb_dec;
	logic [15:0]                      crc_data;
	logic [15:0]                      crc_tx;
	logic [isofrm_pkg::MSG_CNT_W-1:0] open_blm;
	isofrm_pkg::open_t                op;
	isofrm_pkg::rec_t                 rec;
	logic [8:0]                       fs_sat;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign payload  = 8'(frame_size_q - isofrm_pkg::FRAME_OVERHEAD);

	always_comb begin
		start_bytes = in_data.message_bits[14:3];
		if (start_bytes > isofrm_pkg::MAX_MESSAGE_BYTES) begin
			start_bytes = isofrm_pkg::MAX_MESSAGE_BYTES;
		end
		blm_dec  = blm_q - 12'd1;
		blb_dec  = blb_q - 8'd1;
		crc_data = isofrm_pkg::crc_feed(crc_q, in_data.data_byte);
		open_blm = (in_data.kind == isofrm_pkg::KIND_START) ? start_bytes : blm_dec;
		op       = isofrm_pkg::open_block(open_blm, toggle_q, payload, crc_variant_q);
	end

	always_comb begin
		toggle_d = toggle_q;
		blm_d    = blm_q;
		blb_d    = blb_q;
		crc_d    = crc_q;
		active_d = active_q;
		len_d    = len_q;
		produce  = 1'b0;
		rec      = '0;
		crc_tx   = '0;
		if (in_data.kind == isofrm_pkg::KIND_START) begin
			produce  = 1'b1;
			blm_d    = start_bytes;
			blb_d    = op.blb;
			len_d    = op.len;
			crc_d    = op.crc;
			toggle_d = !toggle_q;
			active_d = 1'b1;
			rec.ent[0] = isofrm_pkg::mk_entry(op.pcb, op.len, 1'b1, 1'b0, 1'b0);
			rec.last_idx = 2'd0;
			if (op.blb == 8'd0) begin
				// empty message: PCB-only block closes at once
				crc_tx   = isofrm_pkg::crc_final(op.crc, crc_variant_q);
				rec.ent[1] = isofrm_pkg::mk_entry(crc_tx[7:0], op.len, 1'b0, 1'b0, 1'b0);
				rec.ent[2] = isofrm_pkg::mk_entry(crc_tx[15:8], op.len, 1'b0, 1'b1, 1'b1);
				rec.last_idx = 2'd2;
				active_d = 1'b0;
			end
		end else if (active_q && blb_q != 8'd0) begin
			produce = 1'b1;
			blm_d   = blm_dec;
			blb_d   = blb_dec;
			crc_d   = crc_data;
			rec.ent[0] = isofrm_pkg::mk_entry(in_data.data_byte, len_q, 1'b0, 1'b0, 1'b0);
			rec.last_idx = 2'd0;
			if (blb_dec == 8'd0) begin
				crc_tx = isofrm_pkg::crc_final(crc_data, crc_variant_q);
				rec.ent[1] = isofrm_pkg::mk_entry(crc_tx[7:0], len_q, 1'b0, 1'b0, 1'b0);
				rec.ent[2] = isofrm_pkg::mk_entry(crc_tx[15:8], len_q, 1'b0, 1'b1,
					blm_dec == 12'd0);
				rec.last_idx = 2'd2;
				if (blm_dec == 12'd0) begin
					active_d = 1'b0;
				end else begin
					// payload remains, so the next block is never empty here
					blb_d    = op.blb;
					len_d    = op.len;
					crc_d    = op.crc;
					toggle_d = !toggle_q;
					rec.ent[3] = isofrm_pkg::mk_entry(op.pcb, op.len, 1'b1, 1'b0, 1'b0);
					rec.last_idx = 2'd3;
				end
			end
		end
	end

	assign push.valid = accept && produce;
	assign push.rec   = rec;

	always_comb begin
		fs_sat = cfg_wdata;
		if (cfg_wdata < isofrm_pkg::FRAME_SIZE_MIN) begin
			fs_sat = isofrm_pkg::FRAME_SIZE_MIN;
		end else if (cfg_wdata > isofrm_pkg::FRAME_SIZE_MAX) begin
			fs_sat = isofrm_pkg::FRAME_SIZE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q  <= isofrm_pkg::FRAME_SIZE_RESET;
			crc_variant_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				isofrm_pkg::REG_FRAME_SIZE:  frame_size_q  <= fs_sat;
				isofrm_pkg::REG_CRC_VARIANT: crc_variant_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q <= 1'b0;
			blm_q    <= '0;
			blb_q    <= '0;
			crc_q    <= '0;
			active_q <= 1'b0;
			len_q    <= '0;
		end else if (accept) begin
			toggle_q <= toggle_d;
			blm_q    <= blm_d;
			blb_q    <= blb_d;
			crc_q    <= crc_d;
			active_q <= active_d;
			len_q    <= len_d;
		end
	end

endmodule

// ===== rtl/isofrm_queue.sv =====
// Short record queue between the framing front end and the byte serializer.
// Register storage; the head entry feeds the output directly.
// Depends on isofrm_pkg.
module isofrm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  isofrm_pkg::push_t  push,
	input  logic               pop,
	output logic               full,
	output logic               not_empty,
	output isofrm_pkg::rec_t   head
);

	isofrm_pkg::rec_t                  mem_q [isofrm_pkg::QUEUE_DEPTH];
	logic [isofrm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [isofrm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [isofrm_pkg::QCNT_W-1:0]     count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full      = count_q == isofrm_pkg::QCNT_W'(isofrm_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push.valid && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/isofrm_back.sv =====
// Back end: walks the head record one result byte per transfer.
// Marks the final byte of each record and releases the record after it.
// Depends on isofrm_pkg.
module isofrm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 not_empty,
	input  isofrm_pkg::rec_t     head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output isofrm_pkg::out_item_t out_data
);

	logic [isofrm_pkg::RES_IDX_W-1:0] idx_q;
	isofrm_pkg::res_entry_t           cur;
	logic                             is_last;
	logic                             xfer;

	assign out_valid = not_empty;
	assign cur       = head.ent[idx_q];
	assign is_last   = idx_q == head.last_idx;
	assign xfer      = out_valid && !out_stall;
	assign pop       = xfer && is_last;

	assign out_data.out_byte     = cur.out_byte;
	assign out_data.block_length = cur.block_length;
	assign out_data.block_first  = cur.block_first;
	assign out_data.block_last   = cur.block_last;
	assign out_data.message_done = cur.message_done;
	assign out_data.run_last     = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= is_last ? '0 : idx_q + 1'b1;
		end
	end

	a_idx_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q <= head.last_idx)
		else $error("result index past end of record");

	a_idx_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> idx_q == $past(idx_q))
		else $error("result index moved while stalled");

	a_done_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.message_done |-> out_data.block_last && out_data.run_last)
		else $error("message end not on a closing byte");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> idx_q == '0)
		else $error("result index left nonzero with queue empty");

endmodule

// ===== rtl/iso14443_block_chaining_framer_top.sv =====
// Top level of the ISO 14443-4 I-block chaining framer with CRC_A / CRC_B.
// Instantiates isofrm_front, isofrm_queue and isofrm_back; depends on isofrm_pkg.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | in_data  (kind, message_bits, data_byte)
//   out     | output    | out_valid/out_stall | out_data (byte, length, flags, run_last)
//   cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// An input item is taken every cycle while the 4-record queue has room; the
// front end finishes its framing work in the accepting cycle.
// Results leave one per cycle from the queue head while out_stall is low; an
// item closing a block makes 3 or 4 results. Reset clears the queue, framing
// state and config registers (frame_size 256, CRC_A). in_stall rises only
// while the queue is full.
module iso14443_block_chaining_framer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  isofrm_pkg::in_item_t              in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output isofrm_pkg::out_item_t             out_data,
	input  logic                              cfg_we,
	input  logic [isofrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [isofrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	isofrm_pkg::push_t push;
	isofrm_pkg::rec_t  head;
	logic              q_full;
	logic              q_not_empty;
	logic              pop;

	isofrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push)
	);

	isofrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	isofrm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
